>>> rtl/dlta_pkg.sv
package dlta_pkg;

   localparam int DATA_W = 56;

   typedef enum logic [2:0] {
      PH_OP,
      PH_CNT_HI,
      PH_CNT_LO,
      PH_VTX,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      ENT_TRI,
      ENT_QUAD,
      ENT_BAD_OP,
      ENT_TRUNC
   } entry_kind_type;

   typedef struct packed {
      logic [6:0]  mtx;
      logic [15:0] pos;
      logic [15:0] nrm;
      logic [15:0] clr;
   } vertex_type;

   typedef struct packed {
      entry_kind_type        kind;
      vertex_type [3:0]      vtx;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic [7:0] vertex_bytes;
      logic       matrix_present;
      logic [7:0] pos_offset;
      logic [1:0] pos_mode;
      logic [7:0] nrm_offset;
      logic [1:0] nrm_mode;
      logic [7:0] clr_offset;
      logic [1:0] clr_mode;
   } cfg_type;

   localparam logic [7:0] OP_MASK   = 8'hF8;
   localparam logic [7:0] OP_QUADS  = 8'h80;
   localparam logic [7:0] OP_TRIS   = 8'h90;
   localparam logic [7:0] OP_STRIP  = 8'h98;
   localparam logic [7:0] OP_FAN    = 8'hA0;
   localparam logic [7:0] OP_LINES  = 8'hA8;
   localparam logic [7:0] OP_LSTRIP = 8'hB0;
   localparam logic [7:0] OP_POINTS = 8'hB8;
   localparam logic [7:0] OP_NOP    = 8'h00;

   localparam logic [2:0] PK_QUADS = 3'd0;
   localparam logic [2:0] PK_TRIS  = 3'd2;
   localparam logic [2:0] PK_STRIP = 3'd3;
   localparam logic [2:0] PK_FAN   = 3'd4;

   localparam logic [1:0] MODE_ABSENT = 2'd0;
   localparam logic [1:0] MODE_8      = 2'd1;

   localparam logic [1:0] RK_CORNER = 2'd0;
   localparam logic [1:0] RK_BAD_OP = 2'd1;
   localparam logic [1:0] RK_TRUNC  = 2'd2;

   localparam logic [2:0] CSR_VERTEX_BYTES   = 3'd0;
   localparam logic [2:0] CSR_MATRIX_PRESENT = 3'd1;
   localparam logic [2:0] CSR_POS_OFFSET     = 3'd2;
   localparam logic [2:0] CSR_POS_MODE       = 3'd3;
   localparam logic [2:0] CSR_NRM_OFFSET     = 3'd4;
   localparam logic [2:0] CSR_NRM_MODE       = 3'd5;
   localparam logic [2:0] CSR_CLR_OFFSET     = 3'd6;
   localparam logic [2:0] CSR_CLR_MODE       = 3'd7;

   localparam logic [15:0] DIV3_RECIP = 16'd171;

   function automatic logic [6:0] div3(input logic [7:0] b);
      logic [15:0] p;
      p = {8'd0, b} * DIV3_RECIP;
      return p[15:9];
   endfunction

endpackage

>>> rtl/dlta_front.sv
module dlta_front (
   input  logic               clock,
   input  logic               reset,
   input  dlta_pkg::cfg_type  cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               q_full,
   output dlta_pkg::push_type push
);
   import dlta_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] verts_ff, verts_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  ord_lo_ff, ord_lo_in;
   logic [1:0]  mod3_ff, mod3_in;
   logic        ge2_ff, ge2_in;
   vertex_type  cap_ff, cap_in;
   vertex_type  p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in, anchor_ff, anchor_in;

   logic        accept, is_prim, vtx_done, last_vert, cnt_zero, o_zero, o_one;
   logic        tri_hit, quad_hit;
   logic [7:0]  vb, op;
   vertex_type  cur;
   entry_type   tri_entry;

   function automatic logic [15:0] grab(input logic [15:0] val, input logic [1:0] mode,
                                        input logic [7:0] off, input logic [7:0] i,
                                        input logic [7:0] b);
      logic [15:0] r;
      r = val;
      case (mode)
         MODE_ABSENT: r = val;
         MODE_8: begin
            if (i == off) r = {8'd0, b};
         end
         default: begin
            if (i == off) r[15:8] = b;
            if ({1'b0, i} == ({1'b0, off} + 9'd1)) r[7:0] = b;
         end
      endcase
      return r;
   endfunction

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & ~q_full;

   always_comb begin
      op        = req_tdata & OP_MASK;
      is_prim   = op inside {OP_QUADS, OP_TRIS, OP_STRIP, OP_FAN,
                             OP_LINES, OP_LSTRIP, OP_POINTS};
      vb        = (cfg.vertex_bytes == 8'd0) ? 8'd1 : cfg.vertex_bytes;
      vtx_done  = ({1'b0, byte_ff} + 9'd1) >= {1'b0, vb};
      last_vert = verts_ff == 16'd1;
      cnt_zero  = (verts_ff[15:8] == 8'd0) && (req_tdata == 8'd0);
      o_zero    = !ge2_ff && (ord_lo_ff == 2'd0);
      o_one     = !ge2_ff && (ord_lo_ff == 2'd1);

      cur.mtx = (cfg.matrix_present && byte_ff == 8'd0) ? div3(req_tdata) : cap_ff.mtx;
      cur.pos = grab(cap_ff.pos, cfg.pos_mode, cfg.pos_offset, byte_ff, req_tdata);
      cur.nrm = grab(cap_ff.nrm, cfg.nrm_mode, cfg.nrm_offset, byte_ff, req_tdata);
      cur.clr = grab(cap_ff.clr, cfg.clr_mode, cfg.clr_offset, byte_ff, req_tdata);

      tri_hit   = 1'b0;
      quad_hit  = 1'b0;
      tri_entry = '0;
      tri_entry.kind = ENT_TRI;
      case (kind_ff)
         PK_TRIS: begin
            tri_hit = mod3_ff == 2'd2;
            tri_entry.vtx[0] = p2_ff;
            tri_entry.vtx[1] = p1_ff;
            tri_entry.vtx[2] = cur;
         end
         PK_STRIP: begin
            tri_hit = ge2_ff;
            tri_entry.vtx[0] = ord_lo_ff[0] ? p1_ff : p2_ff;
            tri_entry.vtx[1] = ord_lo_ff[0] ? p2_ff : p1_ff;
            tri_entry.vtx[2] = cur;
         end
         PK_FAN: begin
            tri_hit = ge2_ff;
            tri_entry.vtx[0] = anchor_ff;
            tri_entry.vtx[1] = p1_ff;
            tri_entry.vtx[2] = cur;
         end
         PK_QUADS: begin
            quad_hit = ord_lo_ff == 2'd3;
            tri_entry.kind   = ENT_QUAD;
            tri_entry.vtx[0] = p3_ff;
            tri_entry.vtx[1] = p2_ff;
            tri_entry.vtx[2] = p1_ff;
            tri_entry.vtx[3] = cur;
         end
         default: begin
            tri_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_OP: begin
               if (req_tdata == OP_NOP) phase_in = PH_OP;
               else if (!is_prim) phase_in = req_tlast ? PH_OP : PH_SKIP;
               else phase_in = req_tlast ? PH_OP : PH_CNT_HI;
            end
            PH_CNT_HI: phase_in = req_tlast ? PH_OP : PH_CNT_LO;
            PH_CNT_LO: phase_in = (cnt_zero || req_tlast) ? PH_OP : PH_VTX;
            PH_VTX:    phase_in = ((vtx_done && last_vert) || req_tlast) ? PH_OP : PH_VTX;
            PH_SKIP:   phase_in = req_tlast ? PH_OP : PH_SKIP;
            default:   phase_in = PH_OP;
         endcase
      end
   end

   always_comb begin
      kind_in   = kind_ff;
      verts_in  = verts_ff;
      byte_in   = byte_ff;
      ord_lo_in = ord_lo_ff;
      mod3_in   = mod3_ff;
      ge2_in    = ge2_ff;
      cap_in    = cap_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      p3_in     = p3_ff;
      anchor_in = anchor_ff;
      push      = '0;
      if (accept) begin
         case (phase_ff)
            PH_OP: begin
               if (req_tdata != OP_NOP) begin
                  if (!is_prim) begin
                     push.valid      = 1'b1;
                     push.entry.kind = ENT_BAD_OP;
                  end else begin
                     kind_in = req_tdata[5:3];
                     if (req_tlast) begin
                        push.valid      = 1'b1;
                        push.entry.kind = ENT_TRUNC;
                     end
                  end
               end
            end
            PH_CNT_HI: begin
               verts_in[15:8] = req_tdata;
               if (req_tlast) begin
                  push.valid      = 1'b1;
                  push.entry.kind = ENT_TRUNC;
               end
            end
            PH_CNT_LO: begin
               verts_in[7:0] = req_tdata;
               byte_in       = '0;
               ord_lo_in     = '0;
               mod3_in       = '0;
               ge2_in        = 1'b0;
               cap_in        = '0;
               if (!cnt_zero && req_tlast) begin
                  push.valid      = 1'b1;
                  push.entry.kind = ENT_TRUNC;
               end
            end
            PH_VTX: begin
               if (vtx_done) begin
                  byte_in   = '0;
                  cap_in    = '0;
                  verts_in  = verts_ff - 16'd1;
                  ord_lo_in = ord_lo_ff + 2'd1;
                  mod3_in   = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
                  ge2_in    = ge2_ff | o_one;
                  p1_in     = cur;
                  p2_in     = p1_ff;
                  p3_in     = p2_ff;
                  if (o_zero) anchor_in = cur;
                  if (!last_vert && req_tlast) begin
                     push.valid      = 1'b1;
                     push.entry.kind = ENT_TRUNC;
                  end else if (tri_hit || quad_hit) begin
                     push.valid = 1'b1;
                     push.entry = tri_entry;
                  end
               end else begin
                  byte_in = byte_ff + 8'd1;
                  cap_in  = cur;
                  if (req_tlast) begin
                     push.valid      = 1'b1;
                     push.entry.kind = ENT_TRUNC;
                  end
               end
            end
            default: begin
               push.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OP;
         kind_ff   <= '0;
         verts_ff  <= '0;
         byte_ff   <= '0;
         ord_lo_ff <= '0;
         mod3_ff   <= '0;
         ge2_ff    <= 1'b0;
         cap_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         verts_ff  <= verts_in;
         byte_ff   <= byte_in;
         ord_lo_ff <= ord_lo_in;
         mod3_ff   <= mod3_in;
         ge2_ff    <= ge2_in;
         cap_ff    <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      p3_ff     <= p3_in;
      anchor_ff <= anchor_in;
   end

endmodule

>>> rtl/dlta_queue.sv
module dlta_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  dlta_pkg::push_type  push,
   input  logic                pop,
   output dlta_pkg::entry_type head,
   output logic                q_valid,
   output logic                q_full
);
   import dlta_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type      mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] ptr);
      return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
   endfunction

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == CW'(DEPTH);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push.valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push.entry;
   end

endmodule

>>> rtl/dlta_back.sv
module dlta_back (
   input  logic                          clock,
   input  logic                          reset,
   input  dlta_pkg::entry_type           head,
   input  logic                          q_valid,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dlta_pkg::DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);
   import dlta_pkg::*;

   localparam logic [2:0] STEP_TRI_LAST  = 3'd2;
   localparam logic [2:0] STEP_QUAD_LAST = 3'd5;

   logic [2:0]        step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [1:0]        kind_ff, kind_in;
   logic              last_ff, last_in;
   logic              load, step_last;
   logic [1:0]        sel;
   vertex_type        v;

   always_comb begin
      case (head.kind)
         ENT_TRI:  step_last = step_ff == STEP_TRI_LAST;
         ENT_QUAD: step_last = step_ff == STEP_QUAD_LAST;
         default:  step_last = 1'b1;
      endcase
      case (step_ff)
         3'd0:    sel = 2'd0;
         3'd1:    sel = 2'd1;
         3'd2:    sel = 2'd2;
         3'd3:    sel = 2'd2;
         3'd4:    sel = 2'd3;
         default: sel = 2'd0;
      endcase
      v    = head.vtx[sel];
      load = q_valid && (!valid_ff || rsp_tready);
      pop  = load && step_last;

      step_in  = step_ff;
      valid_in = (valid_ff && !rsp_tready);
      data_in  = data_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (load) begin
         step_in  = step_last ? 3'd0 : step_ff + 3'd1;
         valid_in = 1'b1;
         case (head.kind)
            ENT_BAD_OP: begin
               kind_in = RK_BAD_OP;
               data_in = '0;
               last_in = 1'b0;
            end
            ENT_TRUNC: begin
               kind_in = RK_TRUNC;
               data_in = '0;
               last_in = 1'b0;
            end
            default: begin
               kind_in = RK_CORNER;
               data_in = {1'b0, v.clr, v.nrm, v.pos, v.mtx};
               last_in = (step_ff == STEP_TRI_LAST) || (step_ff == STEP_QUAD_LAST);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> rtl/display_list_triangle_assembler_core.sv
// With an empty queue and an idle port, the first result word of a list byte is written
// into the queue entry and then into the output register before it is valid on the port.
// Throughput: one list byte per cycle while the front queue has room; the output
// register gives one word per cycle while the port is ready; a triangle is 3 words, a quad 6.
// The queue depth sets how many emitting bytes the front may run ahead of the port.
// Reset: synchronous, active high; clears parse state, queue and output valid and
// loads the layout registers with their defaults.
module display_list_triangle_assembler_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] list_byte
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dlta_pkg::DATA_W-1:0] rsp_tdata,   // matrix_slot, pos, nrm, clr, pad
   output logic [1:0]                  rsp_tuser,   // [1:0] result_kind
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_addr,
   input  logic [7:0]                  csr_wdata
);
   import dlta_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   push_type  push;
   entry_type head;
   logic      q_valid, q_full, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_VERTEX_BYTES:   cfg_in.vertex_bytes   = csr_wdata;
            CSR_MATRIX_PRESENT: cfg_in.matrix_present = csr_wdata[0];
            CSR_POS_OFFSET:     cfg_in.pos_offset     = csr_wdata;
            CSR_POS_MODE:       cfg_in.pos_mode       = csr_wdata[1:0];
            CSR_NRM_OFFSET:     cfg_in.nrm_offset     = csr_wdata;
            CSR_NRM_MODE:       cfg_in.nrm_mode       = csr_wdata[1:0];
            CSR_CLR_OFFSET:     cfg_in.clr_offset     = csr_wdata;
            CSR_CLR_MODE:       cfg_in.clr_mode       = csr_wdata[1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                <= '0;
         cfg_ff.vertex_bytes   <= 8'd1;
         cfg_ff.pos_mode       <= 2'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   dlta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .head    (head),
      .q_valid (q_valid),
      .q_full  (q_full)
   );

   dlta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_valid    (q_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/dlta_checker.sv
module dlta_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [dlta_pkg::DATA_W-1:0] rsp_tdata,
   input logic [1:0]                  rsp_tuser,
   input logic                        rsp_tlast
);
   import dlta_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RK_CORNER |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("error word carries corner data");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DATA_W-1] == 1'b0 && rsp_tdata[6:0] <= 7'd85)
      else $error("matrix slot or pad bit out of range");

endmodule

bind display_list_triangle_assembler_core dlta_checker u_dlta_checker (.*);

>>> tb/display_list_triangle_assembler_core_test.sv
`timescale 1ns / 1ps

module display_list_triangle_assembler_core_test;

   import dlta_pkg::*;

   localparam int STUCK_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  slot;
      logic [15:0] pos;
      logic [15:0] nrm;
      logic [15:0] clr;
      logic        last;
   } corner_word;

   class corner_ledger;
      cfg_type    layout;
      phase_type  phase;
      logic [2:0] prim;
      logic [15:0] left;
      logic [7:0] byte_idx;
      logic [15:0] ordinal;
      vertex_type capture;
      vertex_type recent [4];
      corner_word fresh [$];
      corner_word corners_due [$];
      int errors, words, tris, bad_ops, truncs;

      function new();
         layout = '0;
         layout.vertex_bytes = 8'd1;
         layout.pos_mode = 2'd2;
         phase = PH_OP;
         prim = '0;
         left = '0;
         byte_idx = '0;
         ordinal = '0;
         capture = '0;
         foreach (recent[k]) recent[k] = '0;
         errors = 0;
         words = 0;
         tris = 0;
         bad_ops = 0;
         truncs = 0;
      endfunction

      function void set_reg(logic [2:0] addr, logic [7:0] v);
         case (addr)
            CSR_VERTEX_BYTES:   layout.vertex_bytes = v;
            CSR_MATRIX_PRESENT: layout.matrix_present = v[0];
            CSR_POS_OFFSET:     layout.pos_offset = v;
            CSR_POS_MODE:       layout.pos_mode = v[1:0];
            CSR_NRM_OFFSET:     layout.nrm_offset = v;
            CSR_NRM_MODE:       layout.nrm_mode = v[1:0];
            CSR_CLR_OFFSET:     layout.clr_offset = v;
            default:            layout.clr_mode = v[1:0];
         endcase
      endfunction

      function int pending();
         return corners_due.size();
      endfunction

      function bit is_prim(logic [7:0] op);
         case (op)
            OP_QUADS, OP_TRIS, OP_STRIP, OP_FAN, OP_LINES, OP_LSTRIP, OP_POINTS: return 1;
            default: return 0;
         endcase
      endfunction

      function logic [15:0] pick_field(logic [15:0] val, logic [1:0] mode, logic [7:0] off,
                                       int idx, logic [7:0] b);
         if (mode == MODE_ABSENT) return val;
         if (mode == MODE_8) return (idx == int'(off)) ? {8'h00, b} : val;
         if (idx == int'(off)) val = {b, val[7:0]};
         if (idx == int'(off) + 1) val = {val[15:8], b};
         return val;
      endfunction

      function void push_corner(vertex_type v, logic last);
         corner_word w;
         w.kind = RK_CORNER;
         w.slot = v.mtx;
         w.pos = v.pos;
         w.nrm = v.nrm;
         w.clr = v.clr;
         w.last = last;
         fresh.insert(fresh.size(), w);
      endfunction

      function void push_tri(vertex_type a, vertex_type b, vertex_type c);
         push_corner(a, 1'b0);
         push_corner(b, 1'b0);
         push_corner(c, 1'b1);
      endfunction

      function void push_flag(logic [1:0] kind);
         corner_word w;
         w = '0;
         w.kind = kind;
         fresh.insert(fresh.size(), w);
      endfunction

      function void close_vertex();
         int o, slot;
         o = int'(ordinal);
         if (prim == PK_FAN) begin
            slot = (o == 0) ? 0 : 1 + (o & 1);
            recent[slot] = capture;
            if (o >= 2) push_tri(recent[0], recent[1 + ((o - 1) & 1)], recent[1 + (o & 1)]);
            return;
         end
         recent[o & 3] = capture;
         case (prim)
            PK_TRIS: begin
               if (o % 3 == 2) push_tri(recent[(o - 2) & 3], recent[(o - 1) & 3], recent[o & 3]);
            end
            PK_STRIP: begin
               if (o >= 2) begin
                  if ((o & 1) != 0)
                     push_tri(recent[(o - 1) & 3], recent[(o - 2) & 3], recent[o & 3]);
                  else
                     push_tri(recent[(o - 2) & 3], recent[(o - 1) & 3], recent[o & 3]);
               end
            end
            PK_QUADS: begin
               if ((o & 3) == 3) begin
                  push_tri(recent[0], recent[1], recent[2]);
                  push_tri(recent[2], recent[3], recent[0]);
               end
            end
            default: ;
         endcase
      endfunction

      function void take_list_byte(logic [7:0] b, logic last);
         int vb, i;
         bit quiet;
         logic [7:0] op;
         quiet = 0;
         fresh.delete();
         case (phase)
            PH_CNT_HI: begin
               left = {b, 8'h00};
               phase = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               left[7:0] = b;
               byte_idx = '0;
               ordinal = '0;
               capture = '0;
               phase = (left == 16'd0) ? PH_OP : PH_VTX;
            end
            PH_VTX: begin
               vb = (layout.vertex_bytes == 8'd0) ? 1 : int'(layout.vertex_bytes);
               i = int'(byte_idx);
               if (layout.matrix_present && i == 0) capture.mtx = 7'(b / 8'd3);
               capture.pos = pick_field(capture.pos, layout.pos_mode, layout.pos_offset, i, b);
               capture.nrm = pick_field(capture.nrm, layout.nrm_mode, layout.nrm_offset, i, b);
               capture.clr = pick_field(capture.clr, layout.clr_mode, layout.clr_offset, i, b);
               byte_idx = 8'(i + 1);
               if (i + 1 >= vb) begin
                  close_vertex();
                  left = left - 16'd1;
                  ordinal = ordinal + 16'd1;
                  byte_idx = '0;
                  capture = '0;
                  if (left == 16'd0) phase = PH_OP;
               end
            end
            PH_SKIP: begin
               quiet = 1;
               if (last) phase = PH_OP;
            end
            default: begin
               phase = PH_OP;
               op = b & OP_MASK;
               if (b == OP_NOP) begin
                  quiet = 1;
               end else if (!is_prim(op)) begin
                  push_flag(RK_BAD_OP);
                  quiet = 1;
                  phase = last ? PH_OP : PH_SKIP;
               end else begin
                  prim = op[5:3];
                  phase = PH_CNT_HI;
               end
            end
         endcase
         if (!quiet && last && phase != PH_OP) begin
            fresh.delete();
            push_flag(RK_TRUNC);
            phase = PH_OP;
         end
         foreach (fresh[k]) corners_due.insert(corners_due.size(), fresh[k]);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("mismatch: %s", what);
      endtask

      task compare(string name, int got, int want);
         if (got != want)
            report($sformatf("word %0d %s = 0x%0h, wanted 0x%0h", words, name, got, want));
      endtask

      task check_word(logic [1:0] kind, logic [DATA_W-1:0] data, logic last);
         corner_word want;
         if (corners_due.size() == 0) begin
            report($sformatf("word %0d arrived with nothing due (kind %0d)", words, kind));
            words++;
            return;
         end
         want = corners_due.pop_front();
         compare("kind", int'(kind), int'(want.kind));
         compare("matrix_slot", int'(data[6:0]), int'(want.slot));
         compare("pos_index", int'(data[22:7]), int'(want.pos));
         compare("nrm_index", int'(data[38:23]), int'(want.nrm));
         compare("clr_index", int'(data[54:39]), int'(want.clr));
         compare("corner_last", int'(last), int'(want.last));
         if (want.kind == RK_CORNER && want.last) tris++;
         if (want.kind == RK_BAD_OP) bad_ops++;
         if (want.kind == RK_TRUNC) truncs++;
         words++;
      endtask

      task close_out();
         if (corners_due.size() != 0)
            report($sformatf("%0d words never arrived", corners_due.size()));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we;
   logic [2:0]          csr_addr;
   logic [7:0]          csr_wdata;

   corner_ledger ledger;
   logic [8:0]   list_q [$];
   int           span = 1;
   int           bytes_sent = 0;
   int           layouts = 0;
   int           stuck = 0;
   bit           req_gaps = 1;
   bit           rsp_gaps = 1;
   bit           hold_req = 0;

   display_list_triangle_assembler_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
      end
      if (stuck == STUCK_LIMIT) begin
         $display("display_list_triangle_assembler_core_test: errors");
         $finish;
      end
   end

   // receiver: decide at the rising edge, drive at the falling edge
   initial begin
      int stall;
      logic ready_next;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            stall--;
            ready_next = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 3);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         @(negedge clock);
         rsp_tready <= ready_next;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.take_list_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic send_list();
      foreach (list_q[k]) send_byte(list_q[k][7:0], list_q[k][8]);
      list_q.delete();
      if ($urandom_range(0, 19) == 0) drain();
   endtask

   function automatic cfg_type make_layout(int vb, int mtx, int po, int pm, int no, int nm,
                                           int co, int cm);
      cfg_type c;
      c.vertex_bytes = 8'(vb);
      c.matrix_present = 1'(mtx);
      c.pos_offset = 8'(po);
      c.pos_mode = 2'(pm);
      c.nrm_offset = 8'(no);
      c.nrm_mode = 2'(nm);
      c.clr_offset = 8'(co);
      c.clr_mode = 2'(cm);
      return c;
   endfunction

   task automatic load_layout(input cfg_type c);
      logic [7:0] vals [8];
      vals[CSR_VERTEX_BYTES] = c.vertex_bytes;
      vals[CSR_MATRIX_PRESENT] = {7'($urandom), c.matrix_present};
      vals[CSR_POS_OFFSET] = c.pos_offset;
      vals[CSR_POS_MODE] = {6'($urandom), c.pos_mode};
      vals[CSR_NRM_OFFSET] = c.nrm_offset;
      vals[CSR_NRM_MODE] = {6'($urandom), c.nrm_mode};
      vals[CSR_CLR_OFFSET] = c.clr_offset;
      vals[CSR_CLR_MODE] = {6'($urandom), c.clr_mode};
      drain();
      for (int k = 0; k < 8; k++) begin
         csr_we <= 1'b1;
         csr_addr <= 3'(k);
         csr_wdata <= vals[k];
         @(negedge clock);
         ledger.set_reg(3'(k), vals[k]);
      end
      csr_we <= 1'b0;
      span = (c.vertex_bytes == 8'd0) ? 1 : int'(c.vertex_bytes);
      layouts++;
   endtask

   function automatic void add_byte(input logic [8:0] x);
      list_q.insert(list_q.size(), x);
   endfunction

   function automatic void put_seq(input logic [63:0] seq, input int n, input logic last);
      for (int k = n - 1; k >= 0; k--)
         add_byte({(k == 0) ? last : 1'b0, seq[8 * k +: 8]});
   endfunction

   function automatic void add_prim(input logic [7:0] op, input int count);
      add_byte({1'b0, op | 8'($urandom_range(0, 7))});
      add_byte({1'b0, 8'(count >> 8)});
      add_byte({1'b0, 8'(count)});
      repeat (count * span) add_byte({1'b0, 8'($urandom)});
   endfunction

   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 9))
         0, 1:    return OP_QUADS;
         2, 3:    return OP_TRIS;
         4, 5:    return OP_STRIP;
         6, 7:    return OP_FAN;
         8:       return OP_LINES;
         default: return ($urandom_range(0, 1) != 0) ? OP_LSTRIP : OP_POINTS;
      endcase
   endfunction

   function automatic logic [7:0] pick_bad_op();
      if ($urandom_range(0, 1) != 0) return 8'($urandom_range(1, 8'h7F));
      return 8'($urandom_range(8'hC0, 8'hFF));
   endfunction

   function automatic void build_list();
      int r, cut;
      logic [7:0] op;
      logic [8:0] tail;
      r = $urandom_range(0, 99);
      if (r >= 85) begin
         if (r >= 93) add_prim(pick_op(), $urandom_range(0, 4));
         add_byte({1'b0, pick_bad_op()});
         repeat ($urandom_range(0, 5)) add_byte({1'b0, 8'($urandom)});
      end else if (r >= 80) begin
         // open a long primitive and cut it short
         add_byte({1'b0, pick_op()});
         add_byte({1'b0, 8'($urandom_range(1, 255))});
         add_byte({1'b0, 8'($urandom)});
         repeat ($urandom_range(0, 3 * span)) add_byte({1'b0, 8'($urandom)});
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) == 0) add_byte(9'h000);
            op = pick_op();
            if (op == OP_QUADS && $urandom_range(0, 9) < 7)
               add_prim(op, 4 * $urandom_range(0, 2));
            else
               add_prim(op, $urandom_range(0, 8));
         end
         if (r >= 68) begin
            cut = $urandom_range(1, list_q.size());
            while (list_q.size() > cut) void'(list_q.pop_back());
         end
      end
      tail = list_q.pop_back();
      add_byte({1'b1, tail[7:0]});
   endfunction

   task automatic run_lists(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         build_list();
         send_list();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      ledger = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      put_seq(64'h00, 1, 1'b0);
      put_seq(64'h90_00_03_FF_00_80, 6, 1'b0);
      put_seq(64'h80_00_04_01_02_03_04, 7, 1'b0);
      put_seq(64'h12_55_AA, 3, 1'b1);
      put_seq(64'hFF, 1, 1'b1);
      put_seq(64'hA0_00_05_01_02_03_04, 7, 1'b1);
      put_seq(64'h9B_00_03_F0_0F_3C, 6, 1'b0);
      put_seq(64'hA8_00_00, 3, 1'b0);
      put_seq(64'hB0_00, 2, 1'b1);
      put_seq(64'hBF, 1, 1'b1);
      send_list();

      load_layout(make_layout(3, 1, 1, 1, 2, 1, 0, 0));
      run_lists(50);

      load_layout(make_layout(6, 1, 1, 2, 3, 2, 5, 3));
      hold_req = 1'b1;
      add_prim(OP_STRIP, 6);
      put_seq(64'h00, 1, 1'b1);
      send_list();
      run_lists(40);

      load_layout(make_layout(0, 0, 0, 1, 0, 2, 255, 1));
      run_lists(40);

      load_layout(make_layout(20, 1, 19, 2, 0, 3, 128, 2));
      add_prim(OP_TRIS, 3);
      put_seq(64'h00, 1, 1'b1);
      send_list();

      load_layout(make_layout(2, 1, 0, 0, 0, 1, 1, 2));
      run_lists(50);

      load_layout(make_layout(4, 0, 2, 2, 0, 2, 3, 1));
      req_gaps = 0;
      rsp_gaps = 0;
      run_lists(40);

      drain();
      ledger.close_out();
      $display("run covered %0d list bytes over %0d layouts, with a long result stall",
               bytes_sent, layouts + 1);
      $display("checked %0d result words: %0d triangles, %0d bad opcodes, %0d truncated lists",
               ledger.words, ledger.tris, ledger.bad_ops, ledger.truncs);
      if (ledger.errors == 0) begin
         $display("display_list_triangle_assembler_core_test: clean");
      end else begin
         $display("display_list_triangle_assembler_core_test: errors");
      end
      $finish;
   end

endmodule
